[hw/rtl/ctrl_pkg.sv]
// ----------------------------------------------------------------------------
// ctrl_pkg
// Shared constants, operation and status codes, and the transaction token
// that travels along the cell chain of the color table.
// ----------------------------------------------------------------------------
package ctrl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int CH_W        = 8;
  localparam int KEY_W       = 24;
  localparam int COLOR_W     = 32;

  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_FIND_RGB = 3'd2;
  localparam logic [2:0] OP_FIND_ANN = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [KEY_W-1:0]   key;
    logic [CH_W-1:0]    alpha;
    logic [1:0]         status;
    logic [COLOR_W-1:0] color;
    logic               ent_valid;
    logic               found;
    logic [IDX_W-1:0]   fidx;
    logic               inc;
  } token_t;

endpackage

[hw/rtl/color_table_reverse_lookup_top.sv]
// ----------------------------------------------------------------------------
// color_table_reverse_lookup_top
// Color table with write, read, clear and lowest-index search by color,
// built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Transactions enter on in_valid/in_ready and results leave on
// out_valid/out_ready, one result for every input transaction, in order.
// The table_size register is written through cfg_we/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Each transaction is a token that passes one entry cell per cycle while
// the chain is not held, so a result passes the registers of all TABLE_DEPTH
// cells and then the output register. Tokens follow each other through the
// chain, and a new transaction can be accepted in every cycle unless held.
// When the receiver stalls with a result waiting, the whole chain holds
// and in_ready drops until the result is taken.
// Reset clears all valid marks, the entry count and the pipeline, and sets
// table_size to 256. Entry colors are not cleared.
// ----------------------------------------------------------------------------
module color_table_reverse_lookup_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ctrl_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic [ctrl_pkg::IDX_W-1:0]  entry_index,
  input  logic [ctrl_pkg::CH_W-1:0]   red_in,
  input  logic [ctrl_pkg::CH_W-1:0]   green_in,
  input  logic [ctrl_pkg::CH_W-1:0]   blue_in,
  input  logic [ctrl_pkg::CH_W-1:0]   alpha_in,
  input  logic [ctrl_pkg::KEY_W-1:0]  annotation_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [ctrl_pkg::CH_W-1:0]   red_out,
  output logic [ctrl_pkg::CH_W-1:0]   green_out,
  output logic [ctrl_pkg::CH_W-1:0]   blue_out,
  output logic [ctrl_pkg::CH_W-1:0]   alpha_out,
  output logic [ctrl_pkg::KEY_W-1:0]  annotation_out,
  output logic                        entry_valid,
  output logic                        found,
  output logic [ctrl_pkg::IDX_W-1:0]  found_index,
  output logic [ctrl_pkg::CNT_W-1:0]  valid_count
);
  import ctrl_pkg::*;

  logic [CNT_W-1:0] table_size;
  logic [CNT_W-1:0] limit;
  logic             en;
  token_t           head;
  token_t           tok [TABLE_DEPTH+1];
  logic             tv  [TABLE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= CNT_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  assign limit    = (table_size > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : table_size;
  assign in_ready = en;

  always_comb begin
    head          = '0;
    head.op       = opcode;
    head.idx      = entry_index;
    head.in_range = {1'b0, entry_index} < limit;
    head.alpha    = alpha_in;
    if (opcode == OP_FIND_ANN) begin
      head.key = annotation_in;
    end else begin
      head.key = {blue_in, green_in, red_in};
    end
    if ((opcode == OP_WRITE || opcode == OP_READ) && !head.in_range) begin
      head.status = ST_RANGE;
    end
  end

  assign tok[0] = head;
  assign tv[0]  = in_valid;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ctrl_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .en            (en),
      .cell_index    (IDX_W'(i)),
      .limit         (limit),
      .tok_in_valid  (tv[i]),
      .tok_in        (tok[i]),
      .tok_out_valid (tv[i+1]),
      .tok_out       (tok[i+1])
    );
  end

  ctrl_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .tok_valid      (tv[TABLE_DEPTH]),
    .tok            (tok[TABLE_DEPTH]),
    .out_ready      (out_ready),
    .en             (en),
    .out_valid      (out_valid),
    .status         (status),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out),
    .alpha_out      (alpha_out),
    .annotation_out (annotation_out),
    .entry_valid    (entry_valid),
    .found          (found),
    .found_index    (found_index),
    .valid_count    (valid_count)
  );

endmodule

[hw/rtl/ctrl_cell.sv]
// ----------------------------------------------------------------------------
// ctrl_cell
// One table entry with its valid mark. It applies each passing transaction
// to its own entry and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ctrl_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [ctrl_pkg::IDX_W-1:0]  cell_index,
  input  logic [ctrl_pkg::CNT_W-1:0]  limit,
  input  logic                        tok_in_valid,
  input  ctrl_pkg::token_t            tok_in,
  output logic                        tok_out_valid,
  output ctrl_pkg::token_t            tok_out
);
  import ctrl_pkg::*;

  logic               mark;
  logic               mark_next;
  logic [COLOR_W-1:0] color;
  logic [COLOR_W-1:0] color_next;
  token_t             tok_next;
  logic               hit;
  logic               reach;

  always_comb begin
    tok_next   = tok_in;
    mark_next  = mark;
    color_next = color;
    hit        = tok_in.in_range && (tok_in.idx == cell_index);
    reach      = {1'b0, cell_index} < limit;
    if (tok_in_valid) begin
      case (tok_in.op) inside
        OP_WRITE: begin
          if (hit) begin
            if (mark) begin
              tok_next.status = ST_DUP;
            end else begin
              mark_next    = 1'b1;
              color_next   = {tok_in.alpha, tok_in.key};
              tok_next.inc = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (hit) begin
            if (!mark) begin
              tok_next.status = ST_EMPTY;
            end else begin
              tok_next.color     = color;
              tok_next.ent_valid = 1'b1;
            end
          end
        end
        OP_FIND_RGB, OP_FIND_ANN: begin
          if (!tok_in.found && reach && mark && (color[KEY_W-1:0] == tok_in.key)) begin
            tok_next.found = 1'b1;
            tok_next.fidx  = cell_index;
          end
        end
        OP_CLEAR: begin
          mark_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark          <= 1'b0;
      tok_out_valid <= 1'b0;
    end else if (en) begin
      mark          <= mark_next;
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color   <= color_next;
      tok_out <= tok_next;
    end
  end

endmodule

[hw/rtl/ctrl_out_stage.sv]
// ----------------------------------------------------------------------------
// ctrl_out_stage
// Output register at the end of the chain. It keeps the count of valid
// entries and sets the advance enable for the whole chain.
// ----------------------------------------------------------------------------
module ctrl_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tok_valid,
  input  ctrl_pkg::token_t            tok,
  input  logic                        out_ready,
  output logic                        en,
  output logic                        out_valid,
  output logic [1:0]                  status,
  output logic [ctrl_pkg::CH_W-1:0]   red_out,
  output logic [ctrl_pkg::CH_W-1:0]   green_out,
  output logic [ctrl_pkg::CH_W-1:0]   blue_out,
  output logic [ctrl_pkg::CH_W-1:0]   alpha_out,
  output logic [ctrl_pkg::KEY_W-1:0]  annotation_out,
  output logic                        entry_valid,
  output logic                        found,
  output logic [ctrl_pkg::IDX_W-1:0]  found_index,
  output logic [ctrl_pkg::CNT_W-1:0]  valid_count
);
  import ctrl_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             take;

  assign en   = !out_valid || out_ready;
  assign take = en && tok_valid;

  always_comb begin
    count_next = count;
    if (tok.op == OP_CLEAR) begin
      count_next = '0;
    end else if (tok.inc) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        count <= count_next;
      end
      if (en) begin
        out_valid <= tok_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status         <= tok.status;
      red_out        <= tok.color[7:0];
      green_out      <= tok.color[15:8];
      blue_out       <= tok.color[23:16];
      alpha_out      <= tok.color[31:24];
      annotation_out <= tok.color[KEY_W-1:0];
      entry_valid    <= tok.ent_valid;
      found          <= tok.found;
      found_index    <= tok.fidx;
      valid_count    <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("valid entry count exceeds table depth");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_OK && !entry_valid)
    else $error("search result carries read data or an error status");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> found_index == '0)
    else $error("found_index set without a match");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    take && tok.op == OP_CLEAR |=> count == '0)
    else $error("clear did not reset the entry count");

endmodule
